// File: design/frga_pkg.sv
// Shared types, constants and size tables for the font ROM glyph address block.
// Used by frga_locate, frga_apb_regs and font_rom_glyph_address; depends on nothing.
package frga_pkg;

    // Font type codes, in table order.
    localparam logic [2:0] FONT_HANZI_15X16 = 3'd0;
    localparam logic [2:0] FONT_ASCII_7X8   = 3'd1;
    localparam logic [2:0] FONT_GB_8X16     = 3'd2;
    localparam logic [2:0] FONT_ASCII_8X16  = 3'd3;
    localparam logic [2:0] FONT_ASCII_5X7   = 3'd4;
    localparam logic [2:0] FONT_ARIAL       = 3'd5;
    localparam logic [2:0] FONT_BOLD_8X16   = 3'd6;
    localparam logic [2:0] FONT_TIMES       = 3'd7;

    // GB2312 zone layout of the hanzi font.
    localparam logic [7:0]  ZONE_FIRST   = 8'hA1;
    localparam logic [7:0]  SYM_ZONE_LO  = 8'hA1;
    localparam logic [7:0]  SYM_ZONE_HI  = 8'hA3;
    localparam logic [7:0]  A9_ZONE      = 8'hA9;
    localparam logic [7:0]  HZ_ZONE_LO   = 8'hB0;
    localparam logic [7:0]  HZ_ZONE_HI   = 8'hF7;
    localparam logic [6:0]  ZONE_SPAN    = 7'd94;
    localparam logic [12:0] HANZI_START  = 13'd846;
    localparam logic [12:0] A9_START     = 13'd282;

    // Printable ASCII range.
    localparam logic [7:0] ASCII_FIRST = 8'h20;
    localparam logic [7:0] ASCII_LAST  = 8'h7E;

    // GB 8x16 extra zones.
    localparam logic [7:0] GB_ZONE_AA   = 8'hAA;
    localparam logic [7:0] GB_ZONE_AB   = 8'hAB;
    localparam logic [7:0] GB_AA_LAST   = 8'hFE;
    localparam logic [7:0] GB_AB_LAST   = 8'hC0;
    localparam logic [6:0] GB_AB_OFFSET = 7'd95;

    // Base byte addresses in the ROM.
    localparam logic [23:0] BASE_ASCII_7X8  = 24'h0066C0;
    localparam logic [23:0] BASE_GB_8X16    = 24'h03B7D0;
    localparam logic [23:0] BASE_ASCII_8X16 = 24'h03B7C0;
    localparam logic [23:0] BASE_ASCII_5X7  = 24'h03BFC0;
    localparam logic [23:0] BASE_ARIAL      = 24'h03C2C0;
    localparam logic [23:0] BASE_BOLD_8X16  = 24'h03CF80;
    localparam logic [23:0] BASE_TIMES      = 24'h03D580;

    // Bytes per proportional glyph.
    localparam logic [5:0] PROP_GLYPH_BYTES = 6'd34;

    // Reset value of the read opcode register.
    localparam logic [7:0] READ_OPCODE_RESET = 8'h03;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    // One request word.
    typedef struct packed {
        logic [2:0]  font_type;
        logic [15:0] char_code;
    } frga_in_t;

    // One result word.
    typedef struct packed {
        logic [23:0] glyph_addr;
        logic        addr_valid;
        logic [4:0]  glyph_width;
        logic [4:0]  glyph_height;
        logic [4:0]  word_count;
        logic [15:0] command_word_high;
        logic [15:0] command_word_low;
    } frga_out_t;

    // Glyph location found for one request.
    typedef struct packed {
        logic        valid;
        logic [23:0] addr;
    } frga_loc_t;

    // Glyph width in pixels per font.
    function automatic logic [4:0] glyph_width_of(input logic [2:0] font);
        logic [4:0] w;
        case (font)
            FONT_HANZI_15X16: w = 5'd16;
            FONT_ASCII_7X8:   w = 5'd7;
            FONT_GB_8X16:     w = 5'd8;
            FONT_ASCII_8X16:  w = 5'd8;
            FONT_ASCII_5X7:   w = 5'd5;
            FONT_BOLD_8X16:   w = 5'd8;
            default:          w = 5'd0;
        endcase
        return w;
    endfunction

    // Glyph height in pixels per font.
    function automatic logic [4:0] glyph_height_of(input logic [2:0] font);
        logic [4:0] h;
        case (font)
            FONT_HANZI_15X16: h = 5'd16;
            FONT_ASCII_7X8:   h = 5'd8;
            FONT_GB_8X16:     h = 5'd16;
            FONT_ASCII_8X16:  h = 5'd16;
            FONT_ASCII_5X7:   h = 5'd7;
            FONT_BOLD_8X16:   h = 5'd16;
            default:          h = 5'd0;
        endcase
        return h;
    endfunction

endpackage

// File: design/frga_locate.sv
// Combinational glyph locator: byte swap, range checks and ROM address per font.
// Depends on frga_pkg for the font codes, zone constants and base addresses.
module frga_locate (
    input  frga_pkg::frga_in_t  req,
    output frga_pkg::frga_loc_t loc
);
    import frga_pkg::*;

    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        printable;
    logic [6:0]  ascii_idx;
    logic [23:0] ascii_x8;
    logic [23:0] ascii_x16;
    logic [23:0] ascii_x34;
    logic        lo_in_zone;
    logic [7:0]  lo_off;
    logic [7:0]  sym_zone;
    logic [7:0]  hz_zone;
    logic [12:0] sym_glyph;
    logic [12:0] hz_glyph;
    logic [12:0] a9_glyph;
    logic        is_sym;
    logic        is_hz;
    logic        is_a9;
    logic        gb_aa;
    logic        gb_ab;
    logic [6:0]  gb_idx;
    logic [23:0] gb_addr;

    // The low byte as received is the zone (high) byte of the swapped code.
    assign hi = req.char_code[7:0];
    assign lo = req.char_code[15:8];

    // Printable ASCII offsets; the code must fit in one byte.
    assign printable = (hi == 8'h00) && (lo >= ASCII_FIRST) && (lo <= ASCII_LAST);
    assign ascii_idx = 7'(lo - ASCII_FIRST);
    assign ascii_x8  = {14'd0, ascii_idx, 3'd0};
    assign ascii_x16 = {13'd0, ascii_idx, 4'd0};
    assign ascii_x34 = 24'(13'(ascii_idx * PROP_GLYPH_BYTES));

    // Hanzi zones: glyph index within the ROM, 32 bytes per glyph.
    assign lo_in_zone = (lo >= ZONE_FIRST);
    assign lo_off     = lo - ZONE_FIRST;
    assign sym_zone   = hi - SYM_ZONE_LO;
    assign hz_zone    = hi - HZ_ZONE_LO;
    assign is_a9      = (hi == A9_ZONE);
    assign is_sym     = (hi >= SYM_ZONE_LO) && (hi <= SYM_ZONE_HI);
    assign is_hz      = (hi >= HZ_ZONE_LO) && (hi <= HZ_ZONE_HI);
    assign a9_glyph   = A9_START + {5'd0, lo_off};
    assign sym_glyph  = 13'(sym_zone[1:0] * ZONE_SPAN) + {5'd0, lo_off};
    assign hz_glyph   = 13'(hz_zone[6:0] * ZONE_SPAN) + {5'd0, lo_off} + HANZI_START;

    // GB 8x16 extra zones, the second continues after the first.
    assign gb_aa   = (hi == GB_ZONE_AA) && (lo >= ZONE_FIRST) && (lo <= GB_AA_LAST);
    assign gb_ab   = (hi == GB_ZONE_AB) && (lo >= ZONE_FIRST) && (lo <= GB_AB_LAST);
    assign gb_idx  = gb_ab ? (7'(lo_off) + GB_AB_OFFSET) : 7'(lo_off);
    assign gb_addr = {13'd0, gb_idx, 4'd0} + BASE_GB_8X16;

    // Select per font; unmapped codes give address 0.
    always_comb
    begin
        loc = '0;
        case (req.font_type)
            FONT_HANZI_15X16:
            begin
                if (lo_in_zone && is_a9)
                begin
                    loc.valid = 1'b1;
                    loc.addr  = {6'd0, a9_glyph, 5'd0};
                end
                else if (lo_in_zone && is_sym)
                begin
                    loc.valid = 1'b1;
                    loc.addr  = {6'd0, sym_glyph, 5'd0};
                end
                else if (lo_in_zone && is_hz)
                begin
                    loc.valid = 1'b1;
                    loc.addr  = {6'd0, hz_glyph, 5'd0};
                end
            end
            FONT_GB_8X16:
            begin
                if (gb_aa || gb_ab)
                begin
                    loc.valid = 1'b1;
                    loc.addr  = gb_addr;
                end
            end
            FONT_ASCII_7X8:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x8 + BASE_ASCII_7X8) : '0;
            end
            FONT_ASCII_8X16:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x16 + BASE_ASCII_8X16) : '0;
            end
            FONT_ASCII_5X7:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x8 + BASE_ASCII_5X7) : '0;
            end
            FONT_ARIAL:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x34 + BASE_ARIAL) : '0;
            end
            FONT_BOLD_8X16:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x16 + BASE_BOLD_8X16) : '0;
            end
            default:
            begin
                loc.valid = printable;
                loc.addr  = printable ? (ascii_x34 + BASE_TIMES) : '0;
            end
        endcase
    end

endmodule

// File: design/frga_apb_regs.sv
// APB-style configuration register holding the ROM read opcode.
// Depends on frga_pkg for the port widths and the reset value.
module frga_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [frga_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [frga_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [frga_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic [7:0]                       read_opcode
);
    import frga_pkg::*;

    logic [7:0] opcode_reg;
    logic [7:0] opcode_next;
    logic       wr_en;

    // The block has a single register; every byte offset within its word selects it.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[APB_ADDR_W-1:0] == paddr);

    always_comb
    begin
        opcode_next = opcode_reg;
        if (wr_en)
        begin
            opcode_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opcode_reg <= READ_OPCODE_RESET;
        end
        else
        begin
            opcode_reg <= opcode_next;
        end
    end

    // Readback.
    assign prdata      = {{(APB_DATA_W-8){1'b0}}, opcode_reg};
    assign read_opcode = opcode_reg;

endmodule

// File: design/font_rom_glyph_address.sv
// Top level of the font ROM glyph address generator: request register,
// locator logic and result register. Depends on frga_pkg, frga_locate and frga_apb_regs.
//
// Usage:
//   Request channel (char_valid / char_stall / char_word) carries a font type
//   and a character code as received. Result channel (glyph_valid /
//   glyph_stall / glyph_word) returns one word per request: glyph byte
//   address, valid flag, glyph size, 16-bit word count and the two SPI
//   command words. A word moves when valid is high and stall is low.
//   An accepted request passes the request register and then the result register.
//   Throughput is one word per cycle while glyph_stall is low; the request register and
//   the result register form a two-stage pipeline with the locator logic between them.
//   When the receiver stalls, the result word holds, the request register still takes
//   one more word, and char_stall rises only once both stages are full. Reset empties
//   both stages and sets the read opcode to 3. The user writes the opcode over the
//   APB-style port at offset 0 while the block is idle; the block itself does not
//   enforce this.
module font_rom_glyph_address (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    output logic                             char_stall,
    input  frga_pkg::frga_in_t               char_word,
    output logic                             glyph_valid,
    input  logic                             glyph_stall,
    output frga_pkg::frga_out_t              glyph_word,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [frga_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [frga_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [frga_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import frga_pkg::*;

    logic [7:0] opcode;
    logic       req_valid_reg;
    logic       req_valid_next;
    frga_in_t   req_reg;
    frga_in_t   req_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    frga_out_t  out_reg;
    frga_out_t  out_next;
    frga_loc_t  loc;
    logic       out_adv;
    logic       req_adv;
    logic [4:0] w;
    logic [4:0] h;
    logic [9:0] area;

    // Configuration register.
    frga_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .read_opcode (opcode)
    );

    // Glyph locator between the two registers.
    frga_locate u_locate (
        .req (req_reg),
        .loc (loc)
    );

    // Pipeline advance: a stage moves on when the one after it can take a word.
    assign out_adv    = !out_valid_reg || !glyph_stall;
    assign req_adv    = !req_valid_reg || out_adv;
    assign char_stall = !req_adv;

    // Request stage next value.
    always_comb
    begin
        req_valid_next = req_valid_reg;
        req_next       = req_reg;
        if (req_adv)
        begin
            req_valid_next = char_valid;
            req_next       = char_word;
        end
    end

    // Result word assembly from the located glyph and the size tables.
    assign w    = glyph_width_of(req_reg.font_type);
    assign h    = glyph_height_of(req_reg.font_type);
    assign area = 10'(w * h);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_adv)
        begin
            out_valid_next             = req_valid_reg;
            out_next.glyph_addr        = loc.addr;
            out_next.addr_valid        = loc.valid;
            out_next.glyph_width       = w;
            out_next.glyph_height      = h;
            out_next.word_count        = area[8:4];
            out_next.command_word_high = {opcode, loc.addr[23:16]};
            out_next.command_word_low  = loc.addr[15:0];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        out_reg <= out_next;
    end

    assign glyph_valid = out_valid_reg;
    assign glyph_word  = out_reg;

endmodule
